### rtl/keyframe_path_interpolator_macros.svh
// Assertion macros for the keyframe path interpolator checkers.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef KEYFRAME_PATH_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_PATH_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, off during reset
`define KPI_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpi check failed");

// Next-cycle implication, off during reset
`define KPI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpi check failed");

`endif

### rtl/kpi_pkg.sv
// Shared types and constants for the keyframe path interpolator.
// No dependencies.
package kpi_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int COORD_W    = 32;
	localparam int TIME_W     = 32;
	localparam int OFF_W      = TIME_W + 1;
	localparam int SEG_W      = CNT_W;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = TIME_W + SEG_W;
	localparam int DIV_W      = PROD_W + FRAC_W;
	localparam int DCNT_W     = $clog2(DIV_W + 1);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int POINT_W    = 3 * COORD_W;

	typedef enum logic [1:0] {
		CFG_START_TIME  = 2'd0,
		CFG_END_TIME    = 2'd1,
		CFG_CYCLIC_MODE = 2'd2,
		CFG_POINT_COUNT = 2'd3
	} cfg_index_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		K_LOAD,
		K_EMPTY,
		K_QUERY
	} item_kind_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] start_time;
		logic signed [TIME_W-1:0] end_time;
		logic                     cyclic_mode;
		logic [CNT_W-1:0]         point_count;
	} cfg_t;

	typedef struct packed {
		item_kind_t              kind;
		logic [IDX_W-1:0]        idx;
		logic [POINT_W-1:0]      point;
		logic signed [OFF_W-1:0] offset;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t ent;
	} push_t;

	typedef struct packed {
		logic   valid;
		entry_t ent;
	} head_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_REM,
		S_CHECK,
		S_MUL,
		S_DIV,
		S_RD_B,
		S_RD_A,
		S_RD_W,
		S_LERP,
		S_SUM,
		S_OUT
	} back_state_t;

	// Clamp the configured count to the table size
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] lim;
		lim = CNT_W'(MAX_POINTS);
		return (c > lim) ? lim : c;
	endfunction

endpackage

### rtl/kpi_if.sv
// Handshake channels of the keyframe path interpolator.
// Depends on kpi_pkg.
interface kpi_in_if import kpi_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [5:0]                 point_index;
	logic signed [COORD_W-1:0]  load_x;
	logic signed [COORD_W-1:0]  load_y;
	logic signed [COORD_W-1:0]  load_z;
	logic signed [TIME_W-1:0]   query_time;
	modport source (output valid, op, point_index, load_x, load_y, load_z, query_time,
		input ready);
	modport sink (input valid, op, point_index, load_x, load_y, load_z, query_time,
		output ready);
endinterface

interface kpi_out_if import kpi_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  pos_x;
	logic signed [COORD_W-1:0]  pos_y;
	logic signed [COORD_W-1:0]  pos_z;
	modport source (output valid, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface kpi_cfg_if import kpi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        reg_index;
	logic [TIME_W-1:0] data;
	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

### rtl/kpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

### rtl/kpi_front.sv
// Front end: accepts items, classifies them and computes the time offset.
// Depends on kpi_pkg and kpi_if.
module kpi_front import kpi_pkg::*; (
	kpi_in_if.sink in_ch,
	input  cfg_t   cfg,
	input  logic   q_full,
	output push_t  push
);
	logic [CNT_W-1:0] n;

	assign n = clamp_count(cfg.point_count);
	assign in_ch.ready = !q_full;

	// classify the request and build the queue entry
	always_comb begin
		push.push      = in_ch.valid && !q_full;
		push.ent.idx   = in_ch.point_index[IDX_W-1:0];
		push.ent.point = {in_ch.load_x, in_ch.load_y, in_ch.load_z};
		push.ent.offset = OFF_W'($signed(in_ch.query_time)) - OFF_W'($signed(cfg.start_time));
		if (in_ch.op == OP_LOAD) begin
			push.ent.kind = K_LOAD;
		end else if (n == '0) begin
			push.ent.kind = K_EMPTY;
		end else begin
			push.ent.kind = K_QUERY;
		end
	end
endmodule

### rtl/kpi_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on kpi_pkg.
module kpi_fifo import kpi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  full,
	output head_t head
);
	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full    = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign do_push = push.push && !full;
	assign do_pop  = pop && (cnt_q != '0);
	assign head.valid = (cnt_q != '0);
	assign head.ent   = mem_q[rptr_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

	// hold entries
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push.ent;
	end
endmodule

### rtl/kpi_back.sv
// Back end: executes loads and queries with a serial divider and the point RAM.
// Depends on kpi_pkg, kpi_if and kpi_ram.
module kpi_back import kpi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  head_t head,
	output logic  pop,
	kpi_out_if.source out_ch
);
	back_state_t st_q, st_nx;
	entry_t      ent_q;

	logic signed [OFF_W-1:0] loc_q;
	logic [PROD_W-1:0]       prod_q;
	logic [OFF_W:0]          div_rem_q;
	logic [DIV_W-1:0]        div_quo_q;
	logic [OFF_W-1:0]        div_den_q;
	logic [DCNT_W-1:0]       div_cnt_q;
	logic [IDX_W-1:0]        b_q, a_q;
	logic [FRAC_W-1:0]       frac_q;
	logic                    zero_q;
	logic [POINT_W-1:0]      pb_q, pa_q;
	logic signed [OFF_W+FRAC_W:0] lx_q, ly_q, lz_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;

	logic [CNT_W-1:0]        n, segs;
	logic signed [OFF_W-1:0] range;
	logic [OFF_W-1:0]        abs_off, abs_range;
	logic [OFF_W:0]          rem_sh;
	logic                    rem_ge;
	logic [CNT_W-1:0]        seg_w, bsel, asel;
	logic [FRAC_W-1:0]       fsel;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_raddr;
	logic [POINT_W-1:0]      ram_rdata;

	assign n         = clamp_count(cfg.point_count);
	assign segs      = cfg.cyclic_mode ? n : n - 1'b1;
	assign range     = OFF_W'($signed(cfg.end_time)) - OFF_W'($signed(cfg.start_time));
	assign abs_off   = ent_q.offset[OFF_W-1] ? OFF_W'(-ent_q.offset) : ent_q.offset;
	assign abs_range = range[OFF_W-1] ? OFF_W'(-range) : range;

	// one restoring divide step
	assign rem_sh = {div_rem_q[OFF_W-1:0], div_quo_q[DIV_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_den_q});

	// segment and neighbor from the quotient
	always_comb begin
		seg_w = div_quo_q[FRAC_W+CNT_W-1:FRAC_W];
		fsel  = div_quo_q[FRAC_W-1:0];
		bsel  = (seg_w >= n) ? n - 1'b1 : seg_w;
		asel  = bsel + CNT_W'(fsel != '0);
		if (asel >= n) asel = '0;
	end

	kpi_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ent_q.idx),
		.wdata (ent_q.point),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		st_nx = st_q;
		case (st_q)
			S_IDLE:     if (head.valid) st_nx = S_DISPATCH;
			S_DISPATCH: begin
				case (ent_q.kind)
					K_LOAD:  st_nx = S_IDLE;
					K_EMPTY: st_nx = S_SUM;
					K_QUERY: begin
						if (range == '0 || segs == '0) st_nx = S_RD_B;
						else if (cfg.cyclic_mode)      st_nx = S_REM;
						else                           st_nx = S_CHECK;
					end
					default: st_nx = S_IDLE;
				endcase
			end
			S_REM:   if (div_cnt_q == '0) st_nx = S_CHECK;
			S_CHECK: st_nx = (loc_q < 0 || loc_q > range) ? S_RD_B : S_MUL;
			S_MUL:   st_nx = S_DIV;
			S_DIV:   if (div_cnt_q == '0) st_nx = S_RD_B;
			S_RD_B:  st_nx = S_RD_A;
			S_RD_A:  st_nx = S_RD_W;
			S_RD_W:  st_nx = S_LERP;
			S_LERP:  st_nx = S_SUM;
			S_SUM:   st_nx = S_OUT;
			S_OUT:   if (out_ch.ready) st_nx = S_IDLE;
			default: st_nx = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = (st_q == S_IDLE) && head.valid;
		ram_we    = (st_q == S_DISPATCH) && (ent_q.kind == K_LOAD);
		ram_raddr = (st_q == S_RD_A) ? a_q : b_q;
		out_ch.valid = (st_q == S_OUT);
		out_ch.pos_x = px_q;
		out_ch.pos_y = py_q;
		out_ch.pos_z = pz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else         st_q <= st_nx;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				ent_q  <= head.ent;
				zero_q <= 1'b0;
				b_q    <= '0;
				a_q    <= '0;
				frac_q <= '0;
			end
			S_DISPATCH: begin
				loc_q     <= ent_q.offset;
				zero_q    <= (ent_q.kind == K_EMPTY);
				div_rem_q <= '0;
				div_den_q <= abs_range;
				div_quo_q <= {abs_off, (DIV_W-OFF_W)'(0)};
				div_cnt_q <= DCNT_W'(OFF_W);
			end
			S_REM: begin
				if (div_cnt_q != '0) begin
					div_rem_q <= rem_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
					div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q - 1'b1;
				end else begin
					loc_q <= ent_q.offset[OFF_W-1] ? OFF_W'(-div_rem_q[OFF_W-1:0])
						: div_rem_q[OFF_W-1:0];
				end
			end
			S_CHECK: begin
				// a negative offset keeps point 0 even past a negative range
				if (!loc_q[OFF_W-1] && loc_q > range) begin
					b_q <= IDX_W'(n - 1'b1);
					a_q <= IDX_W'(n - 1'b1);
				end
				prod_q <= PROD_W'(loc_q[TIME_W-1:0] * segs);
			end
			S_MUL: begin
				div_rem_q <= '0;
				div_den_q <= range;
				div_quo_q <= {prod_q, FRAC_W'(0)};
				div_cnt_q <= DCNT_W'(DIV_W);
			end
			S_DIV: begin
				if (div_cnt_q != '0) begin
					div_rem_q <= rem_ge ? rem_sh - {1'b0, div_den_q} : rem_sh;
					div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
					div_cnt_q <= div_cnt_q - 1'b1;
				end else begin
					b_q    <= IDX_W'(bsel);
					a_q    <= IDX_W'(asel);
					frac_q <= fsel;
				end
			end
			S_RD_A: pb_q <= ram_rdata;
			S_RD_W: pa_q <= ram_rdata;
			S_LERP: begin
				lx_q <= (OFF_W'($signed(pa_q[3*COORD_W-1:2*COORD_W]))
					- OFF_W'($signed(pb_q[3*COORD_W-1:2*COORD_W])))
					* $signed({1'b0, frac_q});
				ly_q <= (OFF_W'($signed(pa_q[2*COORD_W-1:COORD_W]))
					- OFF_W'($signed(pb_q[2*COORD_W-1:COORD_W])))
					* $signed({1'b0, frac_q});
				lz_q <= (OFF_W'($signed(pa_q[COORD_W-1:0]))
					- OFF_W'($signed(pb_q[COORD_W-1:0])))
					* $signed({1'b0, frac_q});
			end
			S_SUM: begin
				if (zero_q) begin
					px_q <= '0;
					py_q <= '0;
					pz_q <= '0;
				end else begin
					px_q <= pb_q[3*COORD_W-1:2*COORD_W] + COORD_W'(lx_q >>> FRAC_W);
					py_q <= pb_q[2*COORD_W-1:COORD_W] + COORD_W'(ly_q >>> FRAC_W);
					pz_q <= pb_q[COORD_W-1:0] + COORD_W'(lz_q >>> FRAC_W);
				end
			end
			default: ;
		endcase
	end
endmodule

### rtl/keyframe_path_interpolator.sv
// Loads and queries run in the back end; a query may need a 33-step
// remainder in cyclic mode and a 55-step divide in the serial divider.
// The back end handles one item at a time; the front queue holds two more.
// Reset clears control state and configuration registers to zero; the point
// table is undefined until loaded.
// Top level: config registers, front end, queue and back end.
// Depends on kpi_pkg, kpi_if, kpi_front, kpi_fifo, kpi_back.
module keyframe_path_interpolator import kpi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	kpi_cfg_if.sink   cfg_ch,
	kpi_in_if.sink    in_ch,
	kpi_out_if.source out_ch
);
	cfg_t  cfg_q;
	push_t push;
	head_t head;
	logic  q_full, pop;

	assign cfg_ch.ready = 1'b1;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_ch.valid) begin
			case (cfg_index_t'(cfg_ch.reg_index))
				CFG_START_TIME:  cfg_q.start_time  <= cfg_ch.data;
				CFG_END_TIME:    cfg_q.end_time    <= cfg_ch.data;
				CFG_CYCLIC_MODE: cfg_q.cyclic_mode <= cfg_ch.data[0];
				CFG_POINT_COUNT: cfg_q.point_count <= cfg_ch.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	kpi_front u_front (
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push)
	);

	kpi_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	kpi_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule

### rtl/kpi_checker.sv
// Port-level checks for the keyframe path interpolator, bound to the top.
// Depends on kpi_pkg and keyframe_path_interpolator_macros.svh.
`include "keyframe_path_interpolator_macros.svh"
module kpi_checker import kpi_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [COORD_W-1:0] pos_x,
	input logic [COORD_W-1:0] pos_y,
	input logic [COORD_W-1:0] pos_z
);
	// a stalled result stays offered
	`KPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// a stalled result keeps its value
	`KPI_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({pos_x, pos_y, pos_z}))
	// results never come in consecutive cycles
	`KPI_ASSERT_NEXT(a_no_b2b, out_valid && out_ready, !out_valid)
	// configuration port never stalls
	`KPI_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)
endmodule

bind keyframe_path_interpolator kpi_checker u_kpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_ready (cfg_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.pos_x     (out_ch.pos_x),
	.pos_y     (out_ch.pos_y),
	.pos_z     (out_ch.pos_z)
);
